@@ rtl/core/fcsb_pkg.sv @@
`default_nettype none
package fcsb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_PLANES    = 6;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_BUILD  = 2'd1;
  localparam logic [1:0] CMD_SPHERE = 2'd2;
  localparam logic [1:0] CMD_BOX    = 2'd3;

  localparam logic [2:0] PLANE_NEAR = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD,
    OP_SQ,
    OP_SHIFT,
    OP_USQ,
    OP_SQRT,
    OP_DIVN,
    OP_NWR,
    OP_DIVO,
    OP_OINIT,
    OP_OEXT,
    OP_OWR,
    OP_SHORT,
    OP_TST,
    OP_RES
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] plane;
    logic [4:0] step;
    logic [1:0] k;
  } fcsb_cmd_t;

  typedef struct packed {
    logic short_pl;
    logic shift_done;
    logic div_done;
    logic ext_done;
  } fcsb_stat_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [1:0]          mat_row;
    logic [1:0]          mat_col;
    logic signed [31:0]  mat_value;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  pos_z;
    logic signed [31:0]  box_max_x;
    logic signed [31:0]  box_max_y;
    logic signed [31:0]  box_max_z;
    logic signed [31:0]  radius;
  } fcsb_item_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] val);
    logic [31:0] res;
    if (val > 66'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (val < -66'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = val[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fcsb_ifs.sv @@
`default_nettype none
interface fcsb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [1:0]         mat_row;
  logic [1:0]         mat_col;
  logic signed [31:0] mat_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;
  logic signed [31:0] radius;

  modport source (output valid, cmd, mat_row, mat_col, mat_value, pos_x, pos_y, pos_z,
                  box_max_x, box_max_y, box_max_z, radius, input ready);
  modport sink (input valid, cmd, mat_row, mat_col, mat_value, pos_x, pos_y, pos_z,
                box_max_x, box_max_y, box_max_z, radius, output ready);
endinterface

interface fcsb_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic test_done;

  modport source (output valid, inside_res, test_done, input ready);
  modport sink (input valid, inside_res, test_done, output ready);
endinterface
`default_nettype wire

@@ rtl/core/frustum_cull_sphere_box.sv @@
// A matrix write also returns a result; a sphere or box test walks the six planes on one
//   shared 32x32 multiply-accumulate.
// Build time is set by the bit-serial divider (four divides per plane),
//   the 32-step square-root loop and the offset scaling loop; a plane with a near-zero normal skips them.
// Throughput: one transaction in flight; the next is taken while a result waits.
// Reset: synchronous, active high; matrix and plane stores clear to zero at once.
`default_nettype none
module frustum_cull_sphere_box
  import fcsb_pkg::*;
#(
  parameter int COORD_FRAC_BITS = FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  fcsb_in_if.sink    item,
  fcsb_out_if.source result
);

  fcsb_item_t item_pl;
  fcsb_cmd_t  cmd;
  fcsb_stat_t stat;
  logic       in_ready;
  logic       accept;

  assign item_pl = '{
    cmd:       item.cmd,
    mat_row:   item.mat_row,
    mat_col:   item.mat_col,
    mat_value: item.mat_value,
    pos_x:     item.pos_x,
    pos_y:     item.pos_y,
    pos_z:     item.pos_z,
    box_max_x: item.box_max_x,
    box_max_y: item.box_max_y,
    box_max_z: item.box_max_z,
    radius:    item.radius
  };

  assign item.ready = in_ready;
  assign accept     = item.valid && in_ready;

  fcsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_cmd   (item.cmd),
    .in_ready (in_ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcsb_dp #(
    .FRAC_BITS(COORD_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item_pl),
    .cmd       (cmd),
    .stat      (stat),
    .inside_res(result.inside_res),
    .test_done (result.test_done)
  );

endmodule
`default_nettype wire

@@ rtl/core/fcsb_div.sv @@
`default_nettype none
module fcsb_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign done   = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/fcsb_dp.sv @@
`default_nettype none
module fcsb_dp
  import fcsb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  fcsb_item_t item,
  input  fcsb_cmd_t  cmd,
  output fcsb_stat_t stat,
  output logic       inside_res,
  output logic       test_done
);

  localparam logic [63:0] NORM_MIN_SQ = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000000000;
  localparam int          NSH         = 30 - FRAC_BITS;
  localparam logic [5:0]  FRAC6       = 6'(FRAC_BITS);
  localparam logic [34:0] ODM_CLAMP   = 35'd1 << 33;

  logic [31:0] mat [16];
  logic [31:0] nrm [18];
  logic [31:0] ofs [6];

  fcsb_item_t         it;
  logic [31:0]        rdata;
  logic [31:0]        tmp;
  logic signed [32:0] v [3];
  logic signed [32:0] dv;
  logic [32:0]        msh;
  logic [1:0]         rsh;
  logic [4:0]         lsh;
  logic [29:0]        uq [3];
  logic signed [63:0] prod;
  logic [63:0]        s;
  logic [63:0]        sx;
  logic [63:0]        sres;
  logic [63:0]        sbit;
  logic [34:0]        odm;
  logic [31:0]        orem;
  logic [5:0]         ecnt;
  logic signed [65:0] acc;
  logic               insd;

  logic [32:0]        m [3];
  logic [32:0]        mx;
  logic [29:0]        u [3];
  logic [32:0]        dmag;
  logic [30:0]        q;
  logic [1:0]         ki;
  logic [4:0]         nidx;
  logic [4:0]         widx;
  logic [1:0]         col_sel;
  logic [3:0]         rd_addr;
  logic [4:0]         jp;
  logic signed [32:0] ra;
  logic signed [32:0] rt;
  logic signed [32:0] x;
  logic signed [31:0] n_sel;
  logic signed [31:0] lo_c;
  logic signed [31:0] hi_c;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod_next;
  logic signed [33:0] ext;
  logic signed [65:0] total;
  logic [63:0]        trial;
  logic [32:0]        r2;
  logic               oge;
  logic [34:0]        odm_sh;
  logic               rnd;
  logic [35:0]        dmr;
  logic signed [36:0] oval;
  logic [31:0]        nq;
  logic [31:0]        nval;
  logic               is_test;

  logic               div_start;
  logic [63:0]        div_num;
  logic [32:0]        div_den;
  logic [63:0]        quo;
  logic [32:0]        rem;
  logic               div_done;

  always_comb begin
    for (int kk = 0; kk < 3; kk++) begin
      m[kk] = v[kk][32] ? 33'(-v[kk]) : 33'(v[kk]);
      u[kk] = 30'(rsh != 2'd0 ? (m[kk] >> rsh) : (m[kk] << lsh));
    end
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
  end

  assign dmag = dv[32] ? 33'(-dv) : 33'(dv);
  assign q    = sres[30:0];

  assign ki      = (cmd.step[1:0] == 2'd3) ? 2'd0 : cmd.step[1:0];
  assign nidx    = 5'(cmd.plane) * 5'd3 + {3'b0, ki};
  assign widx    = 5'(cmd.plane) * 5'd3 + {3'b0, cmd.k};
  assign col_sel = (cmd.plane < PLANE_NEAR) ? {1'b0, cmd.plane[1]} : 2'd2;
  assign rd_addr = {cmd.step[2:1], cmd.step[0] ? col_sel : 2'd3};
  assign jp      = cmd.step - 5'd1;

  assign ra = 33'($signed(rdata));
  assign rt = 33'($signed(tmp));
  assign x  = (cmd.plane == PLANE_NEAR) ? ra : (cmd.plane[0] ? rt - ra : rt + ra);

  assign is_test = (it.cmd == CMD_SPHERE) || (it.cmd == CMD_BOX);

  always_comb begin
    n_sel = $signed(nrm[nidx]);
    case (ki)
      2'd0: begin
        lo_c = it.pos_x;
        hi_c = it.box_max_x;
      end
      2'd1: begin
        lo_c = it.pos_y;
        hi_c = it.box_max_y;
      end
      default: begin
        lo_c = it.pos_z;
        hi_c = it.box_max_z;
      end
    endcase
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ: begin
        mul_a = $signed({1'b0, m[ki][30:0]});
        mul_b = $signed({1'b0, m[ki][30:0]});
      end
      OP_USQ: begin
        mul_a = $signed({2'b0, u[ki]});
        mul_b = $signed({2'b0, u[ki]});
      end
      OP_TST: begin
        mul_a = n_sel;
        mul_b = (it.cmd == CMD_BOX && n_sel > 32'sd0) ? hi_c : lo_c;
      end
      default: ;
    endcase
  end

  assign prod_next = mul_a * mul_b;

  assign ext   = 34'($signed(ofs[cmd.plane]))
               + ((it.cmd == CMD_SPHERE) ? 34'($signed(it.radius)) : 34'sd0);
  assign total = acc + 66'(prod);

  assign trial = sres + sbit;

  assign r2     = {orem, 1'b0};
  assign oge    = r2 >= {2'b0, q};
  assign odm_sh = {odm[33:0], oge};
  assign rnd    = oge;
  assign dmr    = 36'(odm) + 36'(rnd);
  assign oval   = dv[32] ? -$signed({1'b0, dmr}) : $signed({1'b0, dmr});

  assign nq   = quo[31:0];
  assign nval = v[cmd.k][32] ? 32'(-nq) : nq;

  assign div_start = (cmd.op == OP_DIVN) || (cmd.op == OP_DIVO);
  assign div_num   = (cmd.op == OP_DIVN) ? ((64'(uq[cmd.k]) << 31) + 64'(q)) : 64'(dmag);
  assign div_den   = (cmd.op == OP_DIVN) ? {1'b0, q, 1'b0} : {2'b0, q};

  fcsb_div #(
    .NUM_W(64),
    .DEN_W(33)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (quo),
    .rem  (rem),
    .done (div_done)
  );

  assign stat.short_pl   = (mx[32:31] == 2'b00) && (s <= NORM_MIN_SQ);
  assign stat.shift_done = (msh < (33'd1 << 30)) && (rsh != 2'd0 || msh >= (33'd1 << 29));
  assign stat.div_done   = div_done;
  assign stat.ext_done   = (ecnt == 6'd0);

  // matrix and plane stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) mat[i] <= '0;
      for (int i = 0; i < 18; i++) nrm[i] <= '0;
      for (int i = 0; i < 6; i++) ofs[i] <= '0;
    end else begin
      if (accept && item.cmd == CMD_WRITE) begin
        mat[{item.mat_row, item.mat_col}] <= item.mat_value;
      end
      case (cmd.op)
        OP_NWR: nrm[widx] <= nval;
        OP_SHORT: begin
          for (int kk = 0; kk < 3; kk++) begin
            nrm[5'(cmd.plane) * 5'd3 + 5'(kk)] <= sat32(66'(v[kk]) <<< NSH);
          end
          ofs[cmd.plane] <= sat32(66'(dv));
        end
        OP_OWR: ofs[cmd.plane] <= sat32(66'(oval));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it <= item;
    end
    case (cmd.op)
      OP_RD: begin
        if (cmd.step < 5'd8) begin
          rdata <= mat[rd_addr];
        end
        if (cmd.step != 5'd0) begin
          if (!jp[0]) begin
            tmp <= rdata;
          end else if (jp[2:1] == 2'd3) begin
            dv <= x;
          end else begin
            v[jp[2:1]] <= x;
          end
        end
      end
      OP_SQ: begin
        prod <= prod_next;
        if (cmd.step == 5'd0) begin
          s   <= '0;
          msh <= mx;
          rsh <= '0;
          lsh <= '0;
        end else begin
          s <= s + 64'(prod);
        end
      end
      OP_SHIFT: begin
        if (msh >= (33'd1 << 30)) begin
          msh <= msh >> 1;
          rsh <= rsh + 2'd1;
        end else begin
          msh <= msh << 1;
          lsh <= lsh + 5'd1;
        end
      end
      OP_USQ: begin
        prod <= prod_next;
        if (cmd.step != 5'd3) begin
          uq[ki] <= u[ki];
        end
        if (cmd.step == 5'd0) begin
          s <= '0;
        end else if (cmd.step == 5'd3) begin
          sx   <= s + 64'(prod);
          sres <= '0;
          sbit <= 64'd1 << 62;
        end else begin
          s <= s + 64'(prod);
        end
      end
      OP_SQRT: begin
        if (sx >= trial) begin
          sx   <= sx - trial;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      OP_OINIT: begin
        odm  <= quo[34:0];
        orem <= rem[31:0];
        ecnt <= FRAC6 + 6'(lsh) - 6'(rsh);
      end
      OP_OEXT: begin
        odm  <= (odm_sh > ODM_CLAMP) ? ODM_CLAMP : odm_sh;
        orem <= oge ? 32'(r2 - {2'b0, q}) : r2[31:0];
        ecnt <= ecnt - 6'd1;
      end
      OP_TST: begin
        if (cmd.step == 5'd0) begin
          acc  <= 66'(ext) <<< 30;
          prod <= prod_next;
          if (cmd.plane == 3'd0) begin
            insd <= 1'b1;
          end
        end else if (cmd.step == 5'd3) begin
          if (total[65]) begin
            insd <= 1'b0;
          end
        end else begin
          acc  <= total;
          prod <= prod_next;
        end
      end
      OP_RES: begin
        inside_res <= is_test && insd;
        test_done  <= is_test;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/fcsb_ctrl.sv @@
`default_nettype none
module fcsb_ctrl
  import fcsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  fcsb_stat_t stat,
  output fcsb_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_TST   = 12'b0000_0000_0010,
    S_BRD   = 12'b0000_0000_0100,
    S_BSQ   = 12'b0000_0000_1000,
    S_BCHK  = 12'b0000_0001_0000,
    S_BSH   = 12'b0000_0010_0000,
    S_BUSQ  = 12'b0000_0100_0000,
    S_BSQRT = 12'b0000_1000_0000,
    S_BNDIV = 12'b0001_0000_0000,
    S_BODIV = 12'b0010_0000_0000,
    S_BOEXT = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_t;

  localparam logic [2:0] LAST_PLANE = 3'(NUM_PLANES - 1);

  state_t     state, state_next;
  logic [2:0] plane, plane_next;
  logic [4:0] step, step_next;
  logic [1:0] k, k_next;
  op_t        op;
  logic       accept;
  logic       fin_go;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cmd      = '{op: op, plane: plane, step: step, k: k};

  always_comb begin
    state_next = state;
    plane_next = plane;
    step_next  = step + 5'd1;
    k_next     = k;
    op         = OP_NONE;
    fin_go     = 1'b0;
    case (state)
      S_IDLE: begin
        step_next = '0;
        if (accept) begin
          plane_next = '0;
          k_next     = '0;
          case (in_cmd)
            CMD_WRITE: state_next = S_FIN;
            CMD_BUILD: state_next = S_BRD;
            default:   state_next = S_TST;
          endcase
        end
      end
      S_TST: begin
        op = OP_TST;
        if (step == 5'd3) begin
          step_next = '0;
          if (plane == LAST_PLANE) begin
            state_next = S_FIN;
          end else begin
            plane_next = plane + 3'd1;
          end
        end
      end
      S_BRD: begin
        op = OP_RD;
        if (step == 5'd8) begin
          step_next  = '0;
          state_next = S_BSQ;
        end
      end
      S_BSQ: begin
        op = OP_SQ;
        if (step == 5'd3) begin
          step_next  = '0;
          state_next = S_BCHK;
        end
      end
      S_BCHK: begin
        step_next = '0;
        if (stat.short_pl) begin
          op = OP_SHORT;
          if (plane == LAST_PLANE) begin
            state_next = S_FIN;
          end else begin
            plane_next = plane + 3'd1;
            state_next = S_BRD;
          end
        end else begin
          state_next = S_BSH;
        end
      end
      S_BSH: begin
        step_next = '0;
        if (stat.shift_done) begin
          state_next = S_BUSQ;
        end else begin
          op = OP_SHIFT;
        end
      end
      S_BUSQ: begin
        op = OP_USQ;
        if (step == 5'd3) begin
          step_next  = '0;
          state_next = S_BSQRT;
        end
      end
      S_BSQRT: begin
        op = OP_SQRT;
        if (step == 5'd31) begin
          step_next  = '0;
          k_next     = '0;
          state_next = S_BNDIV;
        end
      end
      S_BNDIV: begin
        if (step == 5'd0) begin
          op = OP_DIVN;
        end else if (stat.div_done) begin
          op        = OP_NWR;
          step_next = '0;
          if (k == 2'd2) begin
            state_next = S_BODIV;
          end else begin
            k_next = k + 2'd1;
          end
        end else begin
          step_next = 5'd1;
        end
      end
      S_BODIV: begin
        if (step == 5'd0) begin
          op = OP_DIVO;
        end else if (stat.div_done) begin
          op         = OP_OINIT;
          step_next  = '0;
          state_next = S_BOEXT;
        end else begin
          step_next = 5'd1;
        end
      end
      S_BOEXT: begin
        step_next = '0;
        if (stat.ext_done) begin
          op = OP_OWR;
          if (plane == LAST_PLANE) begin
            state_next = S_FIN;
          end else begin
            plane_next = plane + 3'd1;
            state_next = S_BRD;
          end
        end else begin
          op = OP_OEXT;
        end
      end
      S_FIN: begin
        step_next = '0;
        if (!out_valid || out_ready) begin
          op         = OP_RES;
          fin_go     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      plane     <= '0;
      step      <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      plane <= plane_next;
      step  <= step_next;
      k     <= k_next;
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("controller idle right after a transaction was taken");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished transaction did not reach the output register");

  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    plane <= LAST_PLANE)
    else $error("plane counter out of range");
`endif

endmodule
`default_nettype wire
